@@ hw/rtl/cei_pkg.sv @@
// Package: constants, types and codes shared by the curtailed energy integrator.
`default_nettype none
package cei_pkg;
  localparam int CurvePoints = 64;
  localparam int IdxW = $clog2(CurvePoints);
  localparam int CntW = $clog2(CurvePoints + 1);
  localparam logic [23:0] ThresholdReset = 24'd3150000;
  localparam logic [47:0] EnergyMax = {48{1'b1}};

  typedef enum logic [1:0] {
    FUNC_POINT = 2'd0,
    FUNC_LIMIT = 2'd1,
    FUNC_WIND  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_USE_EXT   = 3'd1,
    REG_EXT_START = 3'd2,
    REG_EXT_END   = 3'd3,
    REG_COUNT     = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_WAIT, ST_SEG, ST_MUL, ST_DIV, ST_SUM, ST_PROD,
    ST_ACC, ST_OUT
  } state_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic        start;
    logic [39:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [39:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ hw/rtl/cei_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module cei_div
  import cei_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [39:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [16:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[15:0], q_r[39]};
    if (req.start) begin
      q_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = 6'd40;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt = {q_r[38:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quotient = q_r;
endmodule
`default_nettype wire

@@ hw/rtl/curtailed_energy_integrator.sv @@
// Top level: curve memory, run state, interpolation sequencer and register port.
//
//   channel   direction  handshake            payload
//   in_       sink       in_valid/in_ready    func, point_index, speed, power, time, last
//   out_      source     out_valid/out_ready  start/end time, lost energy, count
//   cfg_      APB slave  psel/penable/pready  5 registers at 4*i
//
// Curve writes and limit updates are done in ST_IDLE. A wind sample that adds
// energy reads the curve memory top down, one point per ST_SCAN and ST_SCAN_WAIT
// pair, then, when it interpolates, waits in ST_DIV on the serial divider. A sample
// that ends a run waits in ST_OUT while an earlier result word is still held in
// the output register.
// Reset is synchronous and clears all run state; the curve memory is not cleared.
`default_nettype none
module curtailed_energy_integrator
  import cei_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [5:0]  in_point_index,
  input  wire logic [15:0] in_wind_speed,
  input  wire logic [23:0] in_power_value,
  input  wire logic [31:0] in_sample_time,
  input  wire logic        in_last_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_run_start_time,
  output logic [31:0]      out_run_end_time,
  output logic [47:0]      out_lost_energy,
  output logic [31:0]      out_run_sample_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  // configuration
  logic [23:0] thr_r;
  logic        use_ext_r;
  logic [31:0] ext_start_r, ext_end_r;
  logic [6:0]  ccount_r;
  logic [2:0]  reg_sel;
  assign reg_sel = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThresholdReset;
      use_ext_r <= 1'b1;
      ext_start_r <= '0;
      ext_end_r <= '0;
      ccount_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_THRESHOLD: thr_r <= pwdata[23:0];
        REG_USE_EXT:   use_ext_r <= pwdata[0];
        REG_EXT_START: ext_start_r <= pwdata;
        REG_EXT_END:   ext_end_r <= pwdata;
        REG_COUNT:     ccount_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_THRESHOLD: prdata = {8'd0, thr_r};
      REG_USE_EXT:   prdata = {31'd0, use_ext_r};
      REG_EXT_START: prdata = ext_start_r;
      REG_EXT_END:   prdata = ext_end_r;
      REG_COUNT:     prdata = {25'd0, ccount_r};
      default:       prdata = '0;
    endcase
  end

  // curve memory: speed and power in one word
  logic [39:0]     curve_mem [CurvePoints];
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [39:0]     mem_wdata, mem_rdata_r;
  always_ff @(posedge clk) begin
    if (mem_we) curve_mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= curve_mem[mem_raddr];
  end

  // effective count, clipped to the table depth
  logic [CntW-1:0] n_eff;
  assign n_eff = (ccount_r > 7'(CurvePoints)) ? CntW'(CurvePoints) : CntW'(ccount_r);

  state_t st_r, st_nxt;
  logic [23:0] limit_r, limit_nxt;
  logic [31:0] prev_r, prev_nxt, first_r, first_nxt, cnt_r, cnt_nxt;
  logic [47:0] acc_r, acc_nxt;
  logic        started_r, started_nxt;
  // previous time as it stood before this sample
  logic [31:0] pprev_r;
  // current sample
  logic [15:0] w_r, w_nxt;
  logic [31:0] t_r, t_nxt;
  logic        last_r, last_nxt, add_r, add_nxt;
  // scan
  logic [CntW-1:0] k_r, k_nxt;
  logic            found_r, found_nxt;
  logic [15:0] s0_r, s0_nxt;
  logic [23:0] p0_r, p0_nxt;
  logic [24:0] theory_r, theory_nxt;
  logic [40:0] num_r, num_nxt;  // signed product
  logic        neg_r, neg_nxt;
  logic [15:0] den_r, den_nxt;
  logic [24:0] diff_r, diff_nxt;
  logic [55:0] prod_r, prod_nxt;
  // output register
  logic        ov_r, ov_nxt;
  logic [31:0] os_r, os_nxt, oe_r, oe_nxt, oc_r, oc_nxt;
  logic [47:0] oen_r, oen_nxt;

  div_req_t dreq;
  div_rsp_t drsp;
  cei_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [15:0] rd_s;
  logic [23:0] rd_p;
  logic signed [25:0] dp;
  logic [16:0] dw;
  logic signed [42:0] mprod;
  logic [25:0] sdiff;
  logic [48:0] accsum;
  logic [39:0] absnum;
  assign rd_s = mem_rdata_r[39:24];
  assign rd_p = mem_rdata_r[23:0];

  always_comb begin
    st_nxt = st_r;
    limit_nxt = limit_r; prev_nxt = prev_r; first_nxt = first_r;
    cnt_nxt = cnt_r; acc_nxt = acc_r; started_nxt = started_r;
    w_nxt = w_r; t_nxt = t_r; last_nxt = last_r; add_nxt = add_r;
    k_nxt = k_r; found_nxt = found_r; s0_nxt = s0_r; p0_nxt = p0_r;
    theory_nxt = theory_r; num_nxt = num_r; neg_nxt = neg_r; den_nxt = den_r;
    diff_nxt = diff_r; prod_nxt = prod_r;
    ov_nxt = ov_r; os_nxt = os_r; oe_nxt = oe_r; oc_nxt = oc_r; oen_nxt = oen_r;
    mem_we = 1'b0;
    mem_waddr = in_point_index[IdxW-1:0];
    mem_wdata = {in_wind_speed, in_power_value};
    mem_raddr = IdxW'(k_r);
    dreq.start = 1'b0;
    absnum = num_r[40] ? 40'(-num_r) : num_r[39:0];
    dreq.dividend = absnum;
    dreq.divisor = den_r;
    in_ready = 1'b0;
    dp = '0; dw = '0; mprod = '0; sdiff = '0; accsum = '0;
    if (out_ready) ov_nxt = 1'b0;

    case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (func_t'(in_func))
            FUNC_POINT: mem_we = 1'b1;
            FUNC_LIMIT: limit_nxt = in_power_value;
            FUNC_WIND: begin
              w_nxt = in_wind_speed;
              t_nxt = in_sample_time;
              last_nxt = in_last_sample;
              prev_nxt = in_sample_time;
              add_nxt = started_r && (limit_r < thr_r) && (in_sample_time >= prev_r);
              if (!started_r) begin
                started_nxt = 1'b1;
                first_nxt = in_sample_time;
                cnt_nxt = 32'd1;
              end else if (cnt_r != '1) begin
                cnt_nxt = cnt_r + 32'd1;
              end
              theory_nxt = '0;
              found_nxt = 1'b0;
              k_nxt = n_eff;
              st_nxt = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // issue read of point k-1, going downwards
        if (!add_r || k_r == '0) st_nxt = ST_SUM;
        else begin
          k_nxt = k_r - CntW'(1);
          mem_raddr = IdxW'(k_r - CntW'(1));
          st_nxt = ST_SCAN_WAIT;
        end
      end
      ST_SCAN_WAIT: begin
        if (w_r >= rd_s) begin
          s0_nxt = rd_s; p0_nxt = rd_p;
          theory_nxt = {1'b0, rd_p};
          if (k_r == n_eff - CntW'(1)) st_nxt = ST_SUM;
          else begin
            mem_raddr = IdxW'(k_r + CntW'(1));
            st_nxt = ST_SEG;
          end
        end else st_nxt = ST_SCAN;
      end
      ST_SEG: begin
        // next point has arrived
        if (rd_s <= s0_r) st_nxt = ST_SUM;
        else begin
          den_nxt = rd_s - s0_r;
          dp = $signed({2'b0, rd_p}) - $signed({2'b0, p0_r});
          num_nxt = 41'($signed(dp[24:0]));
          s0_nxt = w_r - s0_r;
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        dw = {1'b0, s0_r};
        mprod = $signed(num_r[24:0]) * $signed(dw);
        num_nxt = mprod[40:0];
        neg_nxt = mprod[42];
        st_nxt = ST_DIV;
        dreq.start = 1'b0;
      end
      ST_DIV: begin
        if (!drsp.busy && !drsp.done && !found_r) begin
          dreq.start = 1'b1;
          found_nxt = 1'b1;
        end else if (drsp.done) begin
          theory_nxt = neg_r ? 25'({1'b0, p0_r} - drsp.quotient[24:0])
                             : 25'({1'b0, p0_r} + drsp.quotient[24:0]);
          st_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sdiff = {1'b0, theory_r} - {2'b0, limit_r};
        diff_nxt = (add_r && !sdiff[25] && sdiff != '0) ? sdiff[24:0] : '0;
        st_nxt = ST_PROD;
      end
      ST_PROD: begin
        prod_nxt = 56'(diff_r) * 56'(t_r - pprev_r);
        st_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (prod_r[55:48] != '0) acc_nxt = EnergyMax;
        else begin
          accsum = {1'b0, acc_r} + {1'b0, prod_r[47:0]};
          acc_nxt = (accsum[48] || accsum[47:0] == EnergyMax) ? EnergyMax : accsum[47:0];
        end
        st_nxt = last_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          os_nxt = use_ext_r ? ext_start_r : first_r;
          oe_nxt = use_ext_r ? ext_end_r : t_r;
          oen_nxt = acc_r;
          oc_nxt = cnt_r;
          limit_nxt = '0; acc_nxt = '0; cnt_nxt = '0; started_nxt = 1'b0;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      limit_r <= '0; prev_r <= '0; first_r <= '0; cnt_r <= '0;
      acc_r <= '0; started_r <= 1'b0; ov_r <= 1'b0; pprev_r <= '0;
    end else begin
      st_r <= st_nxt;
      limit_r <= limit_nxt; prev_r <= prev_nxt; first_r <= first_nxt;
      cnt_r <= cnt_nxt; acc_r <= acc_nxt; started_r <= started_nxt;
      ov_r <= ov_nxt;
      if (st_r == ST_IDLE) pprev_r <= prev_r;
    end
    w_r <= w_nxt; t_r <= t_nxt; last_r <= last_nxt; add_r <= add_nxt;
    k_r <= k_nxt; found_r <= found_nxt; s0_r <= s0_nxt; p0_r <= p0_nxt;
    theory_r <= theory_nxt; num_r <= num_nxt; neg_r <= neg_nxt; den_r <= den_nxt;
    diff_r <= diff_nxt; prod_r <= prod_nxt;
    os_r <= os_nxt; oe_r <= oe_nxt; oc_r <= oc_nxt; oen_r <= oen_nxt;
  end

  assign out_valid = ov_r;
  assign out_run_start_time = os_r;
  assign out_run_end_time = oe_r;
  assign out_lost_energy = oen_r;
  assign out_run_sample_count = oc_r;
endmodule
`default_nettype wire
